@@ sv/pse_pkg.sv @@
`timescale 1ns / 1ps

package pse_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // field widths
  localparam int DATA_W = 32;
  localparam int OPND_W = 31;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 3;

  // token kinds
  localparam logic [FUNC_W-1:0] FN_OPND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SUB  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MUL  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DIV  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_REM  = 3'd5;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 3'd0,
    ST_FEW  = 3'd1,
    ST_LEFT = 3'd2,
    ST_DIVZ = 3'd3,
    ST_OVF  = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic              tok_load;
    logic              we;
    logic              wr_opnd;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              cap_rhs;
    logic              cap_lhs;
    logic              alu_load;
    logic              div_start;
    logic              out_load;
    status_t           out_status;
    logic [FUNC_W-1:0] op;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rhs_zero;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ sv/pse_if.sv @@
`timescale 1ns / 1ps

interface pse_in_if;
  logic                      valid;
  logic                      ready;
  logic [pse_pkg::FUNC_W-1:0] func;
  logic [pse_pkg::OPND_W-1:0] operand_value;
  logic                      last_token;

  modport source (output valid, output func, output operand_value, output last_token,
                  input ready);
  modport sink   (input valid, input func, input operand_value, input last_token,
                  output ready);
endinterface

interface pse_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pse_pkg::DATA_W-1:0] result_value;
  logic [pse_pkg::STAT_W-1:0]        status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

@@ sv/pse_ram.sv @@
`timescale 1ns / 1ps

module pse_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/pse_div.sv @@
`timescale 1ns / 1ps

module pse_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pse_pkg::DATA_W-1:0] dividend,
  input  logic [pse_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [pse_pkg::DATA_W-1:0] quotient,
  output logic [pse_pkg::DATA_W-1:0] remainder
);

  localparam int DW     = pse_pkg::DATA_W;
  localparam int STEP_W = $clog2(DW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     quo_r, quo_nxt;
  logic [DW-1:0]     dvs_r, dvs_nxt;
  logic [DW:0]       shifted;
  logic [DW:0]       diff;
  logic              take;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted  = {rem_r, quo_r[DW-1]};
    diff     = shifted - {1'b0, dvs_r};
    take     = ~diff[DW];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = take ? diff[DW-1:0] : shifted[DW-1:0];
      quo_nxt  = {quo_r[DW-2:0], take};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ sv/pse_dp.sv @@
`timescale 1ns / 1ps

module pse_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pse_pkg::dp_cmd_t                  cmd,
  input  logic [pse_pkg::OPND_W-1:0]        operand_value,
  output pse_pkg::dp_stat_t                 stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pse_pkg::DATA_W-1:0] result_value,
  output logic [pse_pkg::STAT_W-1:0]        status
);

  localparam int DW = pse_pkg::DATA_W;

  logic [pse_pkg::OPND_W-1:0] opnd_r;
  logic [DW-1:0]              rhs_r, lhs_r, res_r;
  logic [DW-1:0]              res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [DW-1:0]              out_result_r;
  logic [pse_pkg::STAT_W-1:0] out_status_r;

  logic [DW-1:0] wdata, rdata;
  logic [DW-1:0] mag_l, mag_r, quo, rem, alu;
  logic          lneg, rneg, div_done, out_free;

  pse_ram #(
    .WIDTH(DW),
    .DEPTH(pse_pkg::STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (cmd.we),
    .waddr(cmd.waddr),
    .wdata(wdata),
    .raddr(cmd.raddr),
    .rdata(rdata)
  );

  assign wdata = cmd.wr_opnd ? {1'b0, opnd_r} : res_r;

  // signed divide done on magnitudes, signs fixed afterwards
  assign lneg  = lhs_r[DW-1];
  assign rneg  = rhs_r[DW-1];
  assign mag_l = lneg ? (~lhs_r + DW'(1)) : lhs_r;
  assign mag_r = rneg ? (~rhs_r + DW'(1)) : rhs_r;

  pse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag_l),
    .divisor  (mag_r),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  always_comb begin
    case (cmd.op)
      pse_pkg::FN_ADD: alu = lhs_r + rhs_r;
      pse_pkg::FN_SUB: alu = lhs_r - rhs_r;
      pse_pkg::FN_MUL: alu = lhs_r * rhs_r;
      default:         alu = '0;
    endcase
    res_nxt = res_r;
    if (cmd.alu_load) begin
      res_nxt = alu;
    end else if (div_done) begin
      if (cmd.op == pse_pkg::FN_REM) begin
        res_nxt = lneg ? (~rem + DW'(1)) : rem;
      end else begin
        res_nxt = (lneg ^ rneg) ? (~quo + DW'(1)) : quo;
      end
    end
  end

  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tok_load) begin
      opnd_r <= operand_value;
    end
    if (cmd.cap_rhs) begin
      rhs_r <= rdata;
    end
    if (cmd.cap_lhs) begin
      lhs_r <= rdata;
    end
    res_r <= res_nxt;
    if (cmd.out_load) begin
      out_result_r <= (cmd.out_status == pse_pkg::ST_OK) ? rdata : '0;
      out_status_r <= cmd.out_status;
    end
  end

  assign stat.rhs_zero = (rhs_r == '0);
  assign stat.div_done = div_done;
  assign stat.out_free = out_free;

  assign out_valid    = out_valid_r;
  assign result_value = out_result_r;
  assign status       = out_status_r;

endmodule

@@ sv/pse_ctrl.sv @@
`timescale 1ns / 1ps

module pse_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pse_pkg::FUNC_W-1:0] in_func,
  input  logic                       in_last,
  input  pse_pkg::dp_stat_t          stat,
  output pse_pkg::dp_cmd_t           cmd
);

  localparam int CW = pse_pkg::CNT_W;
  localparam int AW = pse_pkg::ADDR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_RD_RHS, S_RD_LHS, S_CAP, S_EXEC, S_DIV, S_WRITE, S_END,
    S_FIN_RD, S_FIN_OUT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  pse_pkg::status_t           err_r, err_nxt;
  logic [pse_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic                       last_r, last_nxt;
  logic [CW-1:0]              top1, top2;
  pse_pkg::status_t           fin_status;

  assign top1 = cnt_r - CW'(1);
  assign top2 = cnt_r - CW'(2);

  always_comb begin
    if (err_r != pse_pkg::ST_OK) begin
      fin_status = err_r;
    end else if (cnt_r == '0) begin
      fin_status = pse_pkg::ST_FEW;
    end else if (cnt_r != CW'(1)) begin
      fin_status = pse_pkg::ST_LEFT;
    end else begin
      fin_status = pse_pkg::ST_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    func_nxt  = func_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.op    = func_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.tok_load = 1'b1;
          func_nxt     = in_func;
          last_nxt     = in_last;
          state_nxt    = S_END;
          if (err_r == pse_pkg::ST_OK) begin
            case (in_func) inside
              pse_pkg::FN_OPND: begin
                if (cnt_r == CW'(pse_pkg::STACK_DEPTH)) begin
                  err_nxt = pse_pkg::ST_OVF;
                end else begin
                  state_nxt = S_PUSH;
                end
              end
              pse_pkg::FN_ADD, pse_pkg::FN_SUB, pse_pkg::FN_MUL,
              pse_pkg::FN_DIV, pse_pkg::FN_REM: begin
                if (cnt_r < CW'(2)) begin
                  err_nxt = pse_pkg::ST_FEW;
                end else begin
                  state_nxt = S_RD_RHS;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_PUSH: begin
        cmd.we      = 1'b1;
        cmd.wr_opnd = 1'b1;
        cmd.waddr   = cnt_r[AW-1:0];
        cnt_nxt     = cnt_r + CW'(1);
        state_nxt   = S_END;
      end
      S_RD_RHS: begin
        cmd.raddr = top1[AW-1:0];
        state_nxt = S_RD_LHS;
      end
      S_RD_LHS: begin
        cmd.cap_rhs = 1'b1;
        cmd.raddr   = top2[AW-1:0];
        state_nxt   = S_CAP;
      end
      S_CAP: begin
        cmd.cap_lhs = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        if (func_r == pse_pkg::FN_DIV || func_r == pse_pkg::FN_REM) begin
          if (stat.rhs_zero) begin
            err_nxt   = pse_pkg::ST_DIVZ;
            state_nxt = S_END;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          cmd.alu_load = 1'b1;
          state_nxt    = S_WRITE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.we    = 1'b1;
        cmd.waddr = top2[AW-1:0];
        cnt_nxt   = top1;
        state_nxt = S_END;
      end
      S_END: begin
        state_nxt = last_r ? S_FIN_RD : S_IDLE;
      end
      S_FIN_RD: begin
        state_nxt = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        cmd.out_status = fin_status;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cnt_nxt      = '0;
          err_nxt      = pse_pkg::ST_OK;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      err_r   <= pse_pkg::ST_OK;
      func_r  <= pse_pkg::FN_OPND;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      func_r  <= func_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

@@ sv/postfix_stack_evaluator.sv @@
`timescale 1ns / 1ps

// Postfix (reverse Polish) integer evaluator, one token per input transaction. An operand
// pushes its value onto a 16-entry stack of signed 32-bit values; an operator pops the right
// then the left operand and pushes the wrapped sum, difference, product, truncated quotient
// or remainder. Only a token flagged last_token yields an output transaction: the single
// remaining value with status ok, or 0 with too few operands, values left over, divide by
// zero or stack overflow; the first error is kept and the stack empties afterwards. Tokens
// are taken one at a time: an operand is pushed; add, subtract, multiply, divide and
// remainder read both operands, compute (the latter two in a bit-serial divider giving one
// quotient bit a cycle) and write back; a last token then reads the stack bottom. The stack
// lives in a single-port-read RAM, so the two operands are fetched on successive cycles.
// A finished result sits in an output register; tokens keep flowing while it waits, and only
// a second last token stalls until the first result is taken.

module postfix_stack_evaluator (
  input logic       clk,
  input logic       rst_n,
  pse_in_if.sink    in_tok,
  pse_out_if.source out_res
);

  pse_pkg::dp_cmd_t  cmd;
  pse_pkg::dp_stat_t stat;

  // controller: token sequencing, stack count, sticky error
  pse_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tok.valid),
    .in_ready(in_tok.ready),
    .in_func (in_tok.func),
    .in_last (in_tok.last_token),
    .stat    (stat),
    .cmd     (cmd)
  );

  // datapath: stack ram, operand registers, alu, divider, output register
  pse_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .operand_value(in_tok.operand_value),
    .stat         (stat),
    .out_valid    (out_res.valid),
    .out_ready    (out_res.ready),
    .result_value (out_res.result_value),
    .status       (out_res.status)
  );

endmodule

@@ sv/pse_checker.sv @@
`timescale 1ns / 1ps

module pse_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pse_pkg::DATA_W-1:0] out_result,
  input logic [pse_pkg::STAT_W-1:0] out_status
);

  // last tokens taken whose result has not yet left
  logic [1:0] pend_r, pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if (in_valid && in_ready && in_last) begin
      pend_nxt = pend_nxt + 2'd1;
    end
    if (out_valid && out_ready) begin
      pend_nxt = pend_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result) && $stable(out_status))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pse_pkg::ST_OK |-> out_result == '0)
    else $error("nonzero value with error status");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a last token");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("token taken while previous one in work");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_tok.valid),
  .in_ready  (in_tok.ready),
  .in_last   (in_tok.last_token),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_result(out_res.result_value),
  .out_status(out_res.status)
);
